### rtl/tmn_pkg.sv
// ----------------------------------------------------------------------------
// tmn_pkg
// Shared widths, codes and types of the thruster mixer with proportional
// desaturation.
// ----------------------------------------------------------------------------
package tmn_pkg;

   localparam int CMD_BITS       = 16;
   localparam int THRUSTER_COUNT = 5;
   localparam int AXIS_COUNT     = 5;
   localparam int GAIN_BITS      = 16;
   localparam int GAIN_FRAC      = 12;
   localparam int CFG_COUNT      = 4;

   // exact mixing widths: product of command and gain, sum of three terms
   localparam int PROD_W = CMD_BITS + GAIN_BITS;
   localparam int SUM_W  = PROD_W + 2;

   localparam int REQ_TDATA_W = ((AXIS_COUNT * CMD_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((THRUSTER_COUNT * CMD_BITS + 7) / 8) * 8;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = $clog2(CFG_COUNT) + 2;
   localparam int REG_IDX_W  = $clog2(CFG_COUNT);

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // stage 0 gives the integer bit, the rest one fraction bit each
   localparam int DIV_STAGES = CMD_BITS;

   localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(1) << GAIN_FRAC;
   localparam logic [SUM_W-1:0]     SUM_ONE    = SUM_W'(1) << (CMD_BITS - 1 + GAIN_FRAC);
   localparam logic [CMD_BITS-1:0]  MAG_ONE    = CMD_BITS'(1) << (CMD_BITS - 1);
   localparam logic [CMD_BITS-1:0]  THRUST_MAX = MAG_ONE - CMD_BITS'(1);

   // command fields in req_tdata
   localparam int AXIS_HEAVE = 0;
   localparam int AXIS_PITCH = 1;
   localparam int AXIS_ROLL  = 2;
   localparam int AXIS_SURGE = 3;
   localparam int AXIS_YAW   = 4;

   // thruster fields in rsp_tdata
   localparam int THR_FRONT      = 0;
   localparam int THR_REAR_LEFT  = 1;
   localparam int THR_REAR_RIGHT = 2;
   localparam int THR_LEFT       = 3;
   localparam int THR_RIGHT      = 4;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_PITCH_FRONT = 2'd0,
      REG_PITCH_REAR  = 2'd1,
      REG_ROLL_REAR   = 2'd2,
      REG_YAW_SIDE    = 2'd3
   } tmn_reg_type;

   typedef struct packed {
      logic signed [GAIN_BITS-1:0] pitch_front;
      logic signed [GAIN_BITS-1:0] pitch_rear;
      logic signed [GAIN_BITS-1:0] roll_rear;
      logic signed [GAIN_BITS-1:0] yaw_side;
   } tmn_gains_type;

   // classified item handed from the front to the back
   typedef struct packed {
      logic [THRUSTER_COUNT-1:0][SUM_W-1:0] mag;
      logic [THRUSTER_COUNT-1:0]            neg;
      logic [SUM_W-1:0]                     den;
      logic                                 scaled;
   } tmn_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } tmn_qstat_type;

endpackage

### rtl/tmn_csr.sv
// ----------------------------------------------------------------------------
// tmn_csr
// Mixing gain registers behind the configuration port.
// ----------------------------------------------------------------------------
module tmn_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tmn_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tmn_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tmn_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output tmn_pkg::tmn_gains_type          gains
);
   import tmn_pkg::*;

   tmn_gains_type gains_ff;
   tmn_reg_type   reg_idx;
   logic          wr_en;

   assign reg_idx    = tmn_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign gains      = gains_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.pitch_front <= GAIN_RESET;
         gains_ff.pitch_rear  <= GAIN_RESET;
         gains_ff.roll_rear   <= GAIN_RESET;
         gains_ff.yaw_side    <= GAIN_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_PITCH_FRONT: gains_ff.pitch_front <= csr_pwdata[GAIN_BITS-1:0];
            REG_PITCH_REAR:  gains_ff.pitch_rear  <= csr_pwdata[GAIN_BITS-1:0];
            REG_ROLL_REAR:   gains_ff.roll_rear   <= csr_pwdata[GAIN_BITS-1:0];
            REG_YAW_SIDE:    gains_ff.yaw_side    <= csr_pwdata[GAIN_BITS-1:0];
            default:         gains_ff.yaw_side    <= gains_ff.yaw_side;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_PITCH_FRONT: csr_prdata = CSR_DATA_W'(gains_ff.pitch_front);
         REG_PITCH_REAR:  csr_prdata = CSR_DATA_W'(gains_ff.pitch_rear);
         REG_ROLL_REAR:   csr_prdata = CSR_DATA_W'(gains_ff.roll_rear);
         REG_YAW_SIDE:    csr_prdata = CSR_DATA_W'(gains_ff.yaw_side);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

### rtl/tmn_front.sv
// ----------------------------------------------------------------------------
// tmn_front
// Accepts command sets, mixes them, takes magnitudes and their maximum and
// classifies each item as scaled or plain.
// ----------------------------------------------------------------------------
module tmn_front (
   input  logic                            clock,
   input  logic                            reset,
   input  tmn_pkg::tmn_gains_type          gains,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // heave_cmd, pitch_cmd, roll_cmd, surge_cmd, yaw_cmd
   input  logic [tmn_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  tmn_pkg::tmn_qstat_type          qstat,
   output logic                            push,
   output tmn_pkg::tmn_item_type           item
);
   import tmn_pkg::*;

   logic adv;

   logic signed [CMD_BITS-1:0] cmd [AXIS_COUNT];

   // stage 1: products
   logic                     v1_ff;
   logic signed [CMD_BITS-1:0] heave1_ff, surge1_ff;
   logic signed [PROD_W-1:0] pf1_ff, pr1_ff, rr1_ff, yw1_ff;

   // stage 2: sums
   logic                    v2_ff;
   logic signed [SUM_W-1:0] sum_in [THRUSTER_COUNT];
   logic signed [SUM_W-1:0] sum2_ff [THRUSTER_COUNT];
   logic signed [SUM_W-1:0] heave_q, surge_q;

   // stage 3: magnitudes
   logic                                 v3_ff;
   logic [THRUSTER_COUNT-1:0][SUM_W-1:0] mag3_ff;
   logic [THRUSTER_COUNT-1:0]            neg3_ff;

   // stage 4: pairwise maxima
   logic                                 v4_ff;
   logic [THRUSTER_COUNT-1:0][SUM_W-1:0] mag4_ff;
   logic [THRUSTER_COUNT-1:0]            neg4_ff;
   logic [SUM_W-1:0]                     max_a4_ff, max_b4_ff;

   // stage 5: maximum
   logic                                 v5_ff;
   logic [THRUSTER_COUNT-1:0][SUM_W-1:0] mag5_ff;
   logic [THRUSTER_COUNT-1:0]            neg5_ff;
   logic [SUM_W-1:0]                     max5_ff;
   logic [SUM_W-1:0]                     max_ab, max_in;

   always_comb begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
         cmd[a] = req_tdata[a*CMD_BITS +: CMD_BITS];
      end
   end

   // the front stalls only when its last stage holds an item the queue can't take
   assign adv        = !(v5_ff && qstat.full);
   assign req_tready = adv;
   assign push       = v5_ff && !qstat.full;

   always_comb begin
      heave_q = SUM_W'(heave1_ff) <<< GAIN_FRAC;
      surge_q = SUM_W'(surge1_ff) <<< GAIN_FRAC;
      sum_in[THR_FRONT]      = heave_q + SUM_W'(pf1_ff);
      sum_in[THR_REAR_LEFT]  = heave_q - SUM_W'(pr1_ff) + SUM_W'(rr1_ff);
      sum_in[THR_REAR_RIGHT] = heave_q - SUM_W'(pr1_ff) - SUM_W'(rr1_ff);
      sum_in[THR_LEFT]       = surge_q + SUM_W'(yw1_ff);
      sum_in[THR_RIGHT]      = surge_q - SUM_W'(yw1_ff);
   end

   always_comb begin
      max_ab = (max_a4_ff >= max_b4_ff) ? max_a4_ff : max_b4_ff;
      max_in = (max_ab >= mag4_ff[THR_RIGHT]) ? max_ab : mag4_ff[THR_RIGHT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         heave1_ff <= cmd[AXIS_HEAVE];
         surge1_ff <= cmd[AXIS_SURGE];
         pf1_ff    <= PROD_W'(gains.pitch_front) * PROD_W'(cmd[AXIS_PITCH]);
         pr1_ff    <= PROD_W'(gains.pitch_rear) * PROD_W'(cmd[AXIS_PITCH]);
         rr1_ff    <= PROD_W'(gains.roll_rear) * PROD_W'(cmd[AXIS_ROLL]);
         yw1_ff    <= PROD_W'(gains.yaw_side) * PROD_W'(cmd[AXIS_YAW]);

         for (int t = 0; t < THRUSTER_COUNT; t++) begin
            sum2_ff[t] <= sum_in[t];
            neg3_ff[t] <= sum2_ff[t][SUM_W-1];
            mag3_ff[t] <= sum2_ff[t][SUM_W-1] ? SUM_W'(-sum2_ff[t]) : SUM_W'(sum2_ff[t]);
         end

         mag4_ff   <= mag3_ff;
         neg4_ff   <= neg3_ff;
         max_a4_ff <= (mag3_ff[THR_FRONT] >= mag3_ff[THR_REAR_LEFT]) ?
                      mag3_ff[THR_FRONT] : mag3_ff[THR_REAR_LEFT];
         max_b4_ff <= (mag3_ff[THR_REAR_RIGHT] >= mag3_ff[THR_LEFT]) ?
                      mag3_ff[THR_REAR_RIGHT] : mag3_ff[THR_LEFT];

         mag5_ff <= mag4_ff;
         neg5_ff <= neg4_ff;
         max5_ff <= max_in;
      end
   end

   // a plain item divides by exactly one, which is the rounded shift by GAIN_FRAC
   always_comb begin
      item.mag    = mag5_ff;
      item.neg    = neg5_ff;
      item.scaled = max5_ff > SUM_ONE;
      item.den    = item.scaled ? max5_ff : SUM_ONE;
   end

endmodule

### rtl/tmn_queue.sv
// ----------------------------------------------------------------------------
// tmn_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module tmn_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tmn_pkg::tmn_item_type  wr_item,
   input  logic                   pop,
   output tmn_pkg::tmn_item_type  rd_item,
   output tmn_pkg::tmn_qstat_type qstat
);
   import tmn_pkg::*;

   tmn_item_type           entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff;

   assign qstat.full  = count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign qstat.empty = count_ff == '0;
   assign rd_item     = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         priority if (push && !pop) begin
            count_ff <= count_ff + (QUEUE_PTR_W+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (QUEUE_PTR_W+1)'(1);
         end else begin
            count_ff <= count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

### rtl/tmn_back.sv
// ----------------------------------------------------------------------------
// tmn_back
// Pipelined restoring divider, one quotient bit per stage for all five
// thrusters, then rounding, sign and saturation into the output register.
// ----------------------------------------------------------------------------
module tmn_back (
   input  logic                            clock,
   input  logic                            reset,
   input  tmn_pkg::tmn_item_type           head,
   input  tmn_pkg::tmn_qstat_type          qstat,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // front_vert_thrust, rear_left_thrust, rear_right_thrust,
   // left_horiz_thrust, right_horiz_thrust
   output logic [tmn_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // was_scaled
   output logic                            rsp_tuser
);
   import tmn_pkg::*;

   localparam int LAST = DIV_STAGES - 1;

   logic adv;

   logic                      valid_ff  [DIV_STAGES];
   logic [SUM_W-1:0]          den_ff    [DIV_STAGES];
   logic [THRUSTER_COUNT-1:0] neg_ff    [DIV_STAGES];
   logic                      scaled_ff [DIV_STAGES];
   logic [SUM_W-1:0]          rem_ff    [DIV_STAGES][THRUSTER_COUNT];
   logic [CMD_BITS-1:0]       q_ff      [DIV_STAGES][THRUSTER_COUNT];
   logic [SUM_W-1:0]          rem_in    [DIV_STAGES][THRUSTER_COUNT];
   logic [CMD_BITS-1:0]       q_in      [DIV_STAGES][THRUSTER_COUNT];

   logic                                   out_valid_ff;
   logic [THRUSTER_COUNT*CMD_BITS-1:0]     out_data_ff, out_data_in;
   logic                                   out_scaled_ff;

   assign adv        = !out_valid_ff || rsp_tready;
   assign pop        = adv && !qstat.empty;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(out_data_ff);
   assign rsp_tuser  = out_scaled_ff;

   always_comb begin
      logic [SUM_W:0] rem_sh;
      logic           ge;
      // integer bit: magnitude never exceeds the divisor
      for (int t = 0; t < THRUSTER_COUNT; t++) begin
         ge           = head.mag[t] >= head.den;
         rem_in[0][t] = ge ? (head.mag[t] - head.den) : head.mag[t];
         q_in[0][t]   = CMD_BITS'(ge);
      end
      for (int s = 1; s < DIV_STAGES; s++) begin
         for (int t = 0; t < THRUSTER_COUNT; t++) begin
            rem_sh       = {rem_ff[s-1][t], 1'b0};
            ge           = rem_sh >= {1'b0, den_ff[s-1]};
            rem_in[s][t] = ge ? SUM_W'(rem_sh - {1'b0, den_ff[s-1]}) : SUM_W'(rem_sh);
            q_in[s][t]   = {q_ff[s-1][t][CMD_BITS-2:0], ge};
         end
      end
   end

   // round half away from zero on the magnitude, then sign and clamp plus one
   always_comb begin
      logic                rnd;
      logic [CMD_BITS-1:0] qr;
      for (int t = 0; t < THRUSTER_COUNT; t++) begin
         rnd = {rem_ff[LAST][t], 1'b0} >= {1'b0, den_ff[LAST]};
         qr  = q_ff[LAST][t] + CMD_BITS'(rnd);
         priority if (neg_ff[LAST][t]) begin
            out_data_in[t*CMD_BITS +: CMD_BITS] = CMD_BITS'(-qr);
         end else if (qr == MAG_ONE) begin
            out_data_in[t*CMD_BITS +: CMD_BITS] = THRUST_MAX;
         end else begin
            out_data_in[t*CMD_BITS +: CMD_BITS] = qr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= !qstat.empty;
         for (int s = 1; s < DIV_STAGES; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         out_valid_ff <= valid_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff[0]    <= head.den;
         neg_ff[0]    <= head.neg;
         scaled_ff[0] <= head.scaled;
         for (int s = 1; s < DIV_STAGES; s++) begin
            den_ff[s]    <= den_ff[s-1];
            neg_ff[s]    <= neg_ff[s-1];
            scaled_ff[s] <= scaled_ff[s-1];
         end
         for (int s = 0; s < DIV_STAGES; s++) begin
            for (int t = 0; t < THRUSTER_COUNT; t++) begin
               rem_ff[s][t] <= rem_in[s][t];
               q_ff[s][t]   <= q_in[s][t];
            end
         end
         out_data_ff   <= out_data_in;
         out_scaled_ff <= scaled_ff[LAST];
      end
   end

endmodule

### rtl/thruster_mixer_normalize_unit.sv
// ----------------------------------------------------------------------------
// thruster_mixer_normalize_unit
// Mixes five axis commands into five thruster drives and divides them all
// by the largest magnitude when it exceeds 1.0.
// ----------------------------------------------------------------------------
//  port group   direction   transaction
//  req_*        in          heave, pitch, roll, surge, yaw commands (Q1.15)
//  rsp_*        out         five thruster drives (Q1.15), was_scaled in tuser
//  csr_*        in/out      four Q4.12 mixing gains, byte addresses 0,4,8,12
//
//  One transaction in and one out per cycle when unstalled. rsp_tvalid rises
//  once the item has passed five front stages, the queue write, one divider
//  stage per quotient bit and the output register.
//  The four-entry queue lets the front keep accepting while rsp_tready is low;
//  req_tready falls only once the queue is full. Reset restores all gains to 1.0.
// ----------------------------------------------------------------------------
module thruster_mixer_normalize_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // heave_cmd, pitch_cmd, roll_cmd, surge_cmd, yaw_cmd
   input  logic [tmn_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // front_vert_thrust, rear_left_thrust, rear_right_thrust,
   // left_horiz_thrust, right_horiz_thrust
   output logic [tmn_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // was_scaled
   output logic                            rsp_tuser,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tmn_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tmn_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tmn_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import tmn_pkg::*;

   tmn_gains_type gains;
   tmn_item_type  wr_item, rd_item;
   tmn_qstat_type qstat;
   logic          push, pop;

   tmn_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .gains       (gains)
   );

   tmn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .gains      (gains),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .qstat      (qstat),
      .push       (push),
      .item       (wr_item)
   );

   tmn_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_item (wr_item),
      .pop     (pop),
      .rd_item (rd_item),
      .qstat   (qstat)
   );

   tmn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (rd_item),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
